// File: rtl/shcp_pkg.sv
// ----------------------------------------------------------------------------
// shcp_pkg: hint and challenge packer shared definitions
// Sizes, address bases, status codes and the per-item result bundle.
// ----------------------------------------------------------------------------
package shcp_pkg;

	localparam int N_COEFFS   = 256;
	localparam int HINT_POLYS = 5;
	localparam int MAX_HINTS  = 96;
	localparam int MODULUS    = 8380417;

	localparam int COEF_W = 23;
	localparam int ADDR_W = 8;
	localparam int BYTE_W = 8;
	localparam int STAT_W = 2;

	localparam int BITMAP_BYTES = (N_COEFFS + 7) / 8;
	localparam int J_W          = $clog2(N_COEFFS);
	localparam int POLY_W       = (HINT_POLYS > 1) ? $clog2(HINT_POLYS) : 1;
	localparam int CNT_W        = $clog2(MAX_HINTS + 1);
	localparam int CPOS_W       = $clog2(N_COEFFS + 1);
	localparam int SLOT_W       = 7;
	localparam int SIGN_BYTES   = 8;

	localparam int COUNT_BASE  = MAX_HINTS;
	localparam int BITMAP_BASE = MAX_HINTS + HINT_POLYS;
	localparam int SIGN_BASE   = MAX_HINTS + HINT_POLYS + BITMAP_BYTES;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_DROP = 2'd1;
	localparam logic [STAT_W-1:0] ST_SEQ  = 2'd2;

	localparam logic OP_HINT      = 1'b0;
	localparam logic OP_CHALLENGE = 1'b1;

	typedef struct packed {
		logic              write;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] value;
		logic [STAT_W-1:0] status;
	} res_t;

	// up to two explicit results, optionally followed by the eight sign bytes
	typedef struct packed {
		logic [1:0]  n_expl;
		logic        signs;
		res_t        r0;
		res_t        r1;
		logic [63:0] sign_rec;
	} bundle_t;

endpackage

// File: rtl/signature_hint_challenge_packer.sv
// ----------------------------------------------------------------------------
// signature_hint_challenge_packer: hint and challenge area packer
// Each accepted input item goes through the input register, then the bundle register.
// Throughput: one input item per cycle while results keep up; an item with
//   k results holds the output until all k are sent (up to 10 on the last challenge).
// Reset: arst_n clears all counters, the bitmap and sign record, and the stages.
// ----------------------------------------------------------------------------
module signature_hint_challenge_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [22:0] coefficient, [23] zero
	input  logic [0:0]  s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] byte_address, [15:8] byte_value
	output logic [2:0]  m_tuser,   // [0] write, [2:1] status
	output logic        m_tlast
);

	shcp_pkg::bundle_t bundle;
	shcp_pkg::res_t    res;
	logic              bundle_valid;
	logic              bundle_done;

	shcp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (s_tuser[0]),
		.in_coef      (s_tdata[shcp_pkg::COEF_W-1:0]),
		.bundle_done  (bundle_done),
		.bundle_valid (bundle_valid),
		.bundle       (bundle)
	);

	shcp_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle_valid (bundle_valid),
		.bundle       (bundle),
		.bundle_done  (bundle_done),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_res      (res),
		.out_last     (m_tlast)
	);

	assign m_tdata = {res.value, res.addr};
	assign m_tuser = {res.status, res.write};

endmodule

// File: rtl/shcp_core.sv
// ----------------------------------------------------------------------------
// shcp_core: input register, packing state and result bundle register
// Decodes one coefficient per cycle, while the bundle register is free, into a bundle of byte writes.
// ----------------------------------------------------------------------------
module shcp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_op,
	input  logic [shcp_pkg::COEF_W-1:0]   in_coef,
	input  logic                          bundle_done,
	output logic                          bundle_valid,
	output shcp_pkg::bundle_t             bundle
);

	logic                          valid_s1;
	logic                          op_s1;
	logic [shcp_pkg::COEF_W-1:0]   coef_s1;
	logic                          advance;

	logic [shcp_pkg::J_W-1:0]    j_q;
	logic [shcp_pkg::POLY_W-1:0] poly_q;
	logic                        hints_done_q;
	logic [shcp_pkg::CNT_W-1:0]  index_count_q;
	logic [shcp_pkg::CNT_W-1:0]  pad_pointer_q;
	logic [shcp_pkg::CPOS_W-1:0] cpos_q;
	logic [7:0]                  bitmap_q;
	logic [63:0]                 sign_rec_q;
	logic [shcp_pkg::SLOT_W-1:0] sign_slot_q;

	logic [shcp_pkg::J_W-1:0]    j_d;
	logic [shcp_pkg::POLY_W-1:0] poly_d;
	logic                        hints_done_d;
	logic [shcp_pkg::CNT_W-1:0]  index_count_d;
	logic [shcp_pkg::CNT_W-1:0]  pad_pointer_d;
	logic [shcp_pkg::CPOS_W-1:0] cpos_d;
	logic [7:0]                  bitmap_d;
	logic [63:0]                 sign_rec_d;
	logic [shcp_pkg::SLOT_W-1:0] sign_slot_d;
	shcp_pkg::bundle_t           bundle_d;
	logic                        bundle_valid_d;

	shcp_pkg::res_t res_a;
	shcp_pkg::res_t res_b;
	logic           has_a;
	logic           has_b;
	logic           chal_done;
	logic           last_chal;
	logic [7:0]     bitmap_new;

	assign advance  = valid_s1 && (!bundle_valid || bundle_done);
	assign in_ready = !valid_s1 || advance;
	assign chal_done = (cpos_q == shcp_pkg::CPOS_W'(shcp_pkg::N_COEFFS));
	assign last_chal = (cpos_q == shcp_pkg::CPOS_W'(shcp_pkg::N_COEFFS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= in_op;
			coef_s1 <= in_coef;
		end
	end

	always_comb begin
		j_d           = j_q;
		poly_d        = poly_q;
		hints_done_d  = hints_done_q;
		index_count_d = index_count_q;
		pad_pointer_d = pad_pointer_q;
		cpos_d        = cpos_q;
		bitmap_d      = bitmap_q;
		sign_rec_d    = sign_rec_q;
		sign_slot_d   = sign_slot_q;
		res_a         = '0;
		res_b         = '0;
		has_a         = 1'b0;
		has_b         = 1'b0;
		bitmap_new    = bitmap_q;
		bundle_d      = '0;

		if (op_s1 == shcp_pkg::OP_HINT) begin
			if (hints_done_q) begin
				has_a        = 1'b1;
				res_a.status = shcp_pkg::ST_SEQ;
			end else begin
				if (coef_s1 == shcp_pkg::COEF_W'(1)) begin
					has_a = 1'b1;
					if (index_count_q < shcp_pkg::CNT_W'(shcp_pkg::MAX_HINTS)) begin
						res_a.write   = 1'b1;
						res_a.addr    = shcp_pkg::ADDR_W'(index_count_q);
						res_a.value   = shcp_pkg::BYTE_W'(j_q);
						index_count_d = index_count_q + shcp_pkg::CNT_W'(1);
					end else begin
						res_a.status = shcp_pkg::ST_DROP;
					end
				end
				if (j_q == shcp_pkg::J_W'(shcp_pkg::N_COEFFS - 1)) begin
					has_b       = 1'b1;
					res_b.write = 1'b1;
					res_b.addr  = shcp_pkg::ADDR_W'(shcp_pkg::COUNT_BASE)
					            + shcp_pkg::ADDR_W'(poly_q);
					res_b.value = shcp_pkg::BYTE_W'(index_count_d);
					j_d         = '0;
					if (poly_q == shcp_pkg::POLY_W'(shcp_pkg::HINT_POLYS - 1)) begin
						hints_done_d  = 1'b1;
						pad_pointer_d = index_count_d;
					end else begin
						poly_d = poly_q + shcp_pkg::POLY_W'(1);
					end
				end else begin
					j_d = j_q + shcp_pkg::J_W'(1);
				end
			end
		end else begin
			if (!hints_done_q || chal_done) begin
				has_a        = 1'b1;
				res_a.status = shcp_pkg::ST_SEQ;
			end else begin
				if (pad_pointer_q < shcp_pkg::CNT_W'(shcp_pkg::MAX_HINTS)) begin
					has_a         = 1'b1;
					res_a.write   = 1'b1;
					res_a.addr    = shcp_pkg::ADDR_W'(pad_pointer_q);
					pad_pointer_d = pad_pointer_q + shcp_pkg::CNT_W'(1);
				end
				if (coef_s1 != '0) begin
					bitmap_new = bitmap_q | (8'd1 << cpos_q[2:0]);
					if (sign_slot_q < shcp_pkg::SLOT_W'(64)) begin
						if (coef_s1 == shcp_pkg::COEF_W'(shcp_pkg::MODULUS - 1))
							sign_rec_d[sign_slot_q[5:0]] = 1'b1;
						sign_slot_d = sign_slot_q + shcp_pkg::SLOT_W'(1);
					end
				end
				bitmap_d = bitmap_new;
				cpos_d   = cpos_q + shcp_pkg::CPOS_W'(1);
				if (cpos_q[2:0] == 3'd7 || last_chal) begin
					has_b       = 1'b1;
					res_b.write = 1'b1;
					res_b.addr  = shcp_pkg::ADDR_W'(shcp_pkg::BITMAP_BASE)
					            + shcp_pkg::ADDR_W'(cpos_q[shcp_pkg::CPOS_W-1:3]);
					res_b.value = bitmap_new;
					bitmap_d    = '0;
				end
				bundle_d.signs = last_chal;
			end
		end

		bundle_d.sign_rec = sign_rec_d;
		if (has_a) begin
			bundle_d.r0     = res_a;
			bundle_d.r1     = res_b;
			bundle_d.n_expl = has_b ? 2'd2 : 2'd1;
		end else begin
			bundle_d.r0     = res_b;
			bundle_d.n_expl = has_b ? 2'd1 : 2'd0;
		end
		bundle_valid_d = (bundle_d.n_expl != 2'd0) || bundle_d.signs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q           <= '0;
			poly_q        <= '0;
			hints_done_q  <= 1'b0;
			index_count_q <= '0;
			pad_pointer_q <= '0;
			cpos_q        <= '0;
			bitmap_q      <= '0;
			sign_rec_q    <= '0;
			sign_slot_q   <= '0;
			bundle_valid  <= 1'b0;
		end else begin
			if (advance) begin
				j_q           <= j_d;
				poly_q        <= poly_d;
				hints_done_q  <= hints_done_d;
				index_count_q <= index_count_d;
				pad_pointer_q <= pad_pointer_d;
				cpos_q        <= cpos_d;
				bitmap_q      <= bitmap_d;
				sign_rec_q    <= sign_rec_d;
				sign_slot_q   <= sign_slot_d;
				bundle_valid  <= bundle_valid_d;
			end else if (bundle_done) begin
				bundle_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			bundle <= bundle_d;
	end

endmodule

// File: rtl/shcp_serializer.sv
// ----------------------------------------------------------------------------
// shcp_serializer: result bundle to byte-write stream
// Sends the explicit results, then the sign bytes, one item per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module shcp_serializer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        bundle_valid,
	input  shcp_pkg::bundle_t           bundle,
	output logic                        bundle_done,
	output logic                        out_valid,
	input  logic                        out_ready,
	output shcp_pkg::res_t              out_res,
	output logic                        out_last
);

	logic [3:0] idx_q;
	logic [3:0] total;
	logic [2:0] sign_idx;
	logic       take;

	assign total     = 4'(bundle.n_expl) + (bundle.signs ? 4'd8 : 4'd0);
	assign sign_idx  = 3'(idx_q - 4'(bundle.n_expl));
	assign out_valid = bundle_valid;
	assign out_last  = (idx_q == total - 4'd1);
	assign take      = out_valid && out_ready;
	assign bundle_done = take && out_last;

	always_comb begin
		out_res = '0;
		if (idx_q == 4'd0 && bundle.n_expl != 2'd0) begin
			out_res = bundle.r0;
		end else if (idx_q == 4'd1 && bundle.n_expl == 2'd2) begin
			out_res = bundle.r1;
		end else begin
			out_res.write = 1'b1;
			out_res.addr  = shcp_pkg::ADDR_W'(shcp_pkg::SIGN_BASE) + shcp_pkg::ADDR_W'(sign_idx);
			out_res.value = bundle.sign_rec[8*sign_idx +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= out_last ? 4'd0 : idx_q + 4'd1;
		end
	end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: hint and challenge packer check
// Streams one full signature pass (hint polys, then challenge) with stray
// items mixed in, predicts every byte write alongside, and compares the
// result stream field by field under random idle and stall on both sides.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic                        op;
		logic [shcp_pkg::COEF_W-1:0] coef;
	} coef_item_t;

	typedef struct packed {
		logic                        is_write;
		logic [shcp_pkg::ADDR_W-1:0] addr;
		logic [shcp_pkg::BYTE_W-1:0] value;
		logic [shcp_pkg::STAT_W-1:0] status;
		logic                        last;
	} byte_write_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	signature_hint_challenge_packer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	coef_item_t  coef_stream[$];
	byte_write_t expected_writes[$];

	// packer state mirror
	logic [10:0]                 hint_pos    = '0;
	logic                        hints_done  = 1'b0;
	logic [6:0]                  index_count = '0;
	logic [6:0]                  pad_ptr     = '0;
	logic [shcp_pkg::CPOS_W-1:0] chal_pos    = '0;
	logic [7:0]                  bitmap      = '0;
	logic [63:0]                 signs       = '0;
	logic [6:0]                  sign_slot   = '0;

	int errors     = 0;
	int send_gap   = 0;
	int recv_gap   = 0;
	int send_quiet = 0;
	int recv_quiet = 0;
	logic hold_off = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic byte_write_t make_write(logic w, int a, int v,
			logic [shcp_pkg::STAT_W-1:0] st);
		byte_write_t r;
		r.is_write = w;
		r.addr     = a[shcp_pkg::ADDR_W-1:0];
		r.value    = v[shcp_pkg::BYTE_W-1:0];
		r.status   = st;
		r.last     = 1'b0;
		return r;
	endfunction

	// mostly short gaps, a few long ones, and now and then a quiet stretch
	function automatic int pick_gap(ref int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 2) begin
			quiet = $urandom_range(150, 50);
			return 0;
		end
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic pack_item(input logic op, input logic [shcp_pkg::COEF_W-1:0] c);
		byte_write_t                 batch[$];
		byte_write_t                 w;
		logic [shcp_pkg::J_W-1:0]    j;
		int                          poly;
		logic [shcp_pkg::CPOS_W-1:0] pos;
		logic [2:0]                  bpos;
		if (op == shcp_pkg::OP_HINT) begin
			if (hints_done) begin
				batch.push_back(make_write(1'b0, 0, 0, shcp_pkg::ST_SEQ));
			end else begin
				j    = shcp_pkg::J_W'(int'(hint_pos) % shcp_pkg::N_COEFFS);
				poly = int'(hint_pos) / shcp_pkg::N_COEFFS;
				if (c == shcp_pkg::COEF_W'(1)) begin
					if (index_count < shcp_pkg::MAX_HINTS) begin
						batch.push_back(make_write(1'b1, int'(index_count), int'(j),
							shcp_pkg::ST_OK));
						index_count++;
					end else begin
						batch.push_back(make_write(1'b0, 0, 0, shcp_pkg::ST_DROP));
					end
				end
				if (j == shcp_pkg::J_W'(shcp_pkg::N_COEFFS - 1))
					batch.push_back(make_write(1'b1, shcp_pkg::COUNT_BASE + poly,
						int'(index_count), shcp_pkg::ST_OK));
				hint_pos++;
				if (hint_pos >= shcp_pkg::HINT_POLYS * shcp_pkg::N_COEFFS) begin
					hints_done = 1'b1;
					pad_ptr    = index_count;
				end
			end
		end else begin
			if (!hints_done || chal_pos >= shcp_pkg::N_COEFFS) begin
				batch.push_back(make_write(1'b0, 0, 0, shcp_pkg::ST_SEQ));
			end else begin
				pos  = chal_pos;
				bpos = pos[2:0];
				if (pad_ptr < shcp_pkg::MAX_HINTS) begin
					batch.push_back(make_write(1'b1, int'(pad_ptr), 0, shcp_pkg::ST_OK));
					pad_ptr++;
				end
				if (c != '0) begin
					bitmap[bpos] = 1'b1;
					if (sign_slot < 64) begin
						if (c == shcp_pkg::COEF_W'(shcp_pkg::MODULUS - 1))
							signs[sign_slot] = 1'b1;
						sign_slot++;
					end
				end
				chal_pos++;
				if (bpos == 3'd7 || chal_pos == shcp_pkg::N_COEFFS) begin
					batch.push_back(make_write(1'b1, shcp_pkg::BITMAP_BASE + int'(pos) / 8,
						int'(bitmap), shcp_pkg::ST_OK));
					bitmap = '0;
				end
				if (chal_pos == shcp_pkg::N_COEFFS)
					for (int i = 0; i < shcp_pkg::SIGN_BYTES; i++)
						batch.push_back(make_write(1'b1, shcp_pkg::SIGN_BASE + i,
							int'(signs[8*i +: 8]), shcp_pkg::ST_OK));
			end
		end
		foreach (batch[k]) begin
			w      = batch[k];
			w.last = (k == batch.size() - 1);
			expected_writes.push_back(w);
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic check_result();
		byte_write_t got;
		byte_write_t want;
		got.is_write = m_tuser[0];
		got.status   = m_tuser[2:1];
		got.addr     = m_tdata[7:0];
		got.value    = m_tdata[15:8];
		got.last     = m_tlast;
		if (expected_writes.size() == 0) begin
			report_mismatch("item with nothing pending, addr", int'(got.addr), 0);
		end else begin
			want = expected_writes.pop_front();
			if (got.is_write !== want.is_write)
				report_mismatch("write", int'(got.is_write), int'(want.is_write));
			if (got.addr !== want.addr)
				report_mismatch("byte_address", int'(got.addr), int'(want.addr));
			if (got.value !== want.value)
				report_mismatch("byte_value", int'(got.value), int'(want.value));
			if (got.status !== want.status)
				report_mismatch("status", int'(got.status), int'(want.status));
			if (got.last !== want.last)
				report_mismatch("last", int'(got.last), int'(want.last));
		end
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (send_gap > 0) begin
			s_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (coef_stream.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tdata  <= {1'b0, coef_stream[0].coef};
			s_tuser  <= coef_stream[0].op;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			pack_item(s_tuser[0], s_tdata[shcp_pkg::COEF_W-1:0]);
			void'(coef_stream.pop_front());
			send_gap <= pick_gap(send_quiet);
		end
	end

	// receiver
	always @(negedge clk) begin
		if (!arst_n || hold_off) begin
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			m_tready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			check_result();
			recv_gap <= pick_gap(recv_quiet);
		end
	end

	// long receiver stall during the challenge phase so the block backs up
	initial begin
		wait (chal_pos >= 16);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#40000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [shcp_pkg::COEF_W-1:0] rand_coef();
		return shcp_pkg::COEF_W'($urandom_range(shcp_pkg::MODULUS - 1, 0));
	endfunction

	task automatic add_item(input logic op, input logic [shcp_pkg::COEF_W-1:0] c);
		coef_item_t it;
		it.op   = op;
		it.coef = c;
		coef_stream.push_back(it);
	endtask

	initial begin
		logic [shcp_pkg::COEF_W-1:0] c;
		int                          ones;
		int                          r;
		bit                          dense;
		ones = 0;
		// challenge before the hint phase is out of sequence
		add_item(shcp_pkg::OP_CHALLENGE, '0);
		add_item(shcp_pkg::OP_CHALLENGE, shcp_pkg::COEF_W'(shcp_pkg::MODULUS - 1));
		// one reset only: either overflow the index area or leave room for padding
		dense = 1'($urandom_range(1, 0));
		for (int hp = 0; hp < shcp_pkg::HINT_POLYS * shcp_pkg::N_COEFFS; hp++) begin
			if ($urandom_range(99, 0) < 3)
				add_item(shcp_pkg::OP_CHALLENGE, rand_coef());
			case (hp)
				0:       c = shcp_pkg::COEF_W'(1);
				1:       c = '0;
				2:       c = shcp_pkg::COEF_W'(shcp_pkg::MODULUS - 1);
				3:       c = shcp_pkg::COEF_W'(2);
				4:       c = shcp_pkg::COEF_W'(1);
				5:       c = 23'h400000;
				default: begin
					r = $urandom_range(99, 0);
					if (r < (dense ? 25 : 6))
						c = shcp_pkg::COEF_W'(1);
					else if (r < 50)
						c = '0;
					else
						c = rand_coef();
				end
			endcase
			// a one on the last coefficient gives index and count together
			if (hp % shcp_pkg::N_COEFFS == shcp_pkg::N_COEFFS - 1 &&
					(hp / shcp_pkg::N_COEFFS == 0 ||
					 hp / shcp_pkg::N_COEFFS == shcp_pkg::HINT_POLYS - 1))
				c = shcp_pkg::COEF_W'(1);
			if (!dense && c == shcp_pkg::COEF_W'(1)) begin
				if (ones >= shcp_pkg::MAX_HINTS - 6)
					c = '0;
				else
					ones++;
			end
			add_item(shcp_pkg::OP_HINT, c);
		end
		for (int cp = 0; cp < shcp_pkg::N_COEFFS; cp++) begin
			if ($urandom_range(99, 0) < 3)
				add_item(shcp_pkg::OP_HINT, rand_coef());
			case (cp)
				0:       c = '0;
				1:       c = shcp_pkg::COEF_W'(shcp_pkg::MODULUS - 1);
				2:       c = shcp_pkg::COEF_W'(1);
				3:       c = shcp_pkg::COEF_W'(shcp_pkg::MODULUS - 2);
				default: begin
					r = $urandom_range(99, 0);
					if (r < 40)
						c = '0;
					else if (r < 65)
						c = shcp_pkg::COEF_W'(shcp_pkg::MODULUS - 1);
					else if (r < 80)
						c = shcp_pkg::COEF_W'(1);
					else
						c = rand_coef();
				end
			endcase
			add_item(shcp_pkg::OP_CHALLENGE, c);
		end
		// everything after the challenge phase is reported as out of sequence
		for (int k = 0; k < 10; k++)
			add_item(1'($urandom_range(1, 0)), rand_coef());

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (coef_stream.size() == 0);
		wait (expected_writes.size() == 0);
		repeat (30) @(posedge clk);
		if (errors == 0 && expected_writes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
